/* hdl/b64sd_pkg.sv */
package b64sd_pkg;

    // Character codes of the alphabet and the pad mark
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [7:0] OFS_LOWER = 8'd26;
    localparam logic [7:0] OFS_DIGIT = 8'd52;
    localparam logic [5:0] SX_PLUS   = 6'd62;
    localparam logic [5:0] SX_SLASH  = 6'd63;

    // Positions of the last character of a group and of the first pad
    localparam logic [1:0] POS_LAST = 2'd3;
    localparam logic [1:0] POS_PAD  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LEN  = 2'd1,
        ST_CHAR = 2'd2
    } status_t;

    // One queued command: up to three result beats
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nres;
        logic       done;
        status_t    status;
    } cmd_t;

    // Map a character to {bad, sextet}
    function automatic logic [6:0] to_sextet(input logic [7:0] c);
        logic [7:0] d;
        logic       bad;
        begin
            d   = 8'd0;
            bad = 1'b0;
            if (c >= CH_UP_A && c <= CH_UP_Z)
            begin
                d = c - CH_UP_A;
            end
            else if (c >= CH_LO_A && c <= CH_LO_Z)
            begin
                d = c - CH_LO_A + OFS_LOWER;
            end
            else if (c >= CH_DIG_0 && c <= CH_DIG_9)
            begin
                d = c - CH_DIG_0 + OFS_DIGIT;
            end
            else if (c == CH_PLUS)
            begin
                d = {2'b00, SX_PLUS};
            end
            else if (c == CH_SLASH)
            begin
                d = {2'b00, SX_SLASH};
            end
            else
            begin
                bad = 1'b1;
            end
            return {bad, d[5:0]};
        end
    endfunction

endpackage

/* hdl/b64sd_front.sv */
module b64sd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [7:0]      enc_char,
    input  logic            final_char,
    input  logic            q_full,
    output logic            q_wr,
    output b64sd_pkg::cmd_t q_cmd
);

    logic [1:0] group_pos_reg, group_pos_next;
    logic [5:0] sx0_reg, sx0_next;
    logic [5:0] sx1_reg, sx1_next;
    logic [5:0] sx2_reg, sx2_next;
    logic       pad_seen_reg, pad_seen_next;
    logic       drop_reg, drop_next;

    logic       accept;
    logic       emit;
    logic       is_pad;
    logic [6:0] sx_dec;
    logic       bad;
    logic [5:0] sx;
    logic [7:0] b0, b1, b2;
    b64sd_pkg::cmd_t cmd;

    assign accept = push && !q_full;
    assign is_pad = (enc_char == b64sd_pkg::CH_PAD);
    assign sx_dec = b64sd_pkg::to_sextet(enc_char);
    assign bad    = sx_dec[6];
    assign sx     = sx_dec[5:0];
    assign b0     = {sx0_reg, sx1_reg[5:4]};
    assign b1     = {sx1_reg[3:0], sx2_reg[5:2]};
    assign b2     = {sx2_reg[1:0], sx};

    always_comb
    begin
        group_pos_next = group_pos_reg;
        sx0_next       = sx0_reg;
        sx1_next       = sx1_reg;
        sx2_next       = sx2_reg;
        pad_seen_next  = pad_seen_reg;
        drop_next      = drop_reg;
        emit           = 1'b0;
        cmd.b0         = 8'd0;
        cmd.b1         = 8'd0;
        cmd.b2         = 8'd0;
        cmd.nres       = 2'd1;
        cmd.done       = 1'b1;
        cmd.status     = b64sd_pkg::ST_OK;

        if (drop_reg)
        begin
            // drop until the final character of the failed stream
            if (final_char)
            begin
                drop_next = 1'b0;
            end
        end
        else if ((final_char && group_pos_reg != b64sd_pkg::POS_LAST)
                 || (!is_pad && bad)
                 || (is_pad && group_pos_reg < b64sd_pkg::POS_PAD)
                 || (is_pad && group_pos_reg == b64sd_pkg::POS_LAST && !final_char)
                 || (!is_pad && pad_seen_reg))
        begin
            emit       = 1'b1;
            cmd.status = (final_char && group_pos_reg != b64sd_pkg::POS_LAST)
                         ? b64sd_pkg::ST_LEN : b64sd_pkg::ST_CHAR;
            drop_next  = !final_char;
            group_pos_next = 2'd0;
            pad_seen_next  = 1'b0;
            sx0_next = 6'd0;
            sx1_next = 6'd0;
            sx2_next = 6'd0;
        end
        else if (is_pad && group_pos_reg == b64sd_pkg::POS_PAD)
        begin
            pad_seen_next  = 1'b1;
            group_pos_next = b64sd_pkg::POS_LAST;
        end
        else if (group_pos_reg != b64sd_pkg::POS_LAST)
        begin
            case (group_pos_reg)
                2'd0:    sx0_next = sx;
                2'd1:    sx1_next = sx;
                default: sx2_next = sx;
            endcase
            group_pos_next = group_pos_reg + 2'd1;
        end
        else
        begin
            // group complete: one, two or three octets
            emit   = 1'b1;
            cmd.b0 = b0;
            cmd.b1 = b1;
            cmd.b2 = b2;
            if (is_pad)
            begin
                cmd.nres = pad_seen_reg ? 2'd1 : 2'd2;
                cmd.done = 1'b1;
            end
            else
            begin
                cmd.nres = 2'd3;
                cmd.done = final_char;
            end
            group_pos_next = 2'd0;
            pad_seen_next  = 1'b0;
            sx0_next = 6'd0;
            sx1_next = 6'd0;
            sx2_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos_reg <= 2'd0;
            sx0_reg       <= 6'd0;
            sx1_reg       <= 6'd0;
            sx2_reg       <= 6'd0;
            pad_seen_reg  <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else if (accept)
        begin
            group_pos_reg <= group_pos_next;
            sx0_reg       <= sx0_next;
            sx1_reg       <= sx1_next;
            sx2_reg       <= sx2_next;
            pad_seen_reg  <= pad_seen_next;
            drop_reg      <= drop_next;
        end
    end

    assign q_wr  = accept && emit;
    assign q_cmd = cmd;

endmodule

/* hdl/b64sd_fifo.sv */
module b64sd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  b64sd_pkg::cmd_t wr_cmd,
    input  logic            rd,
    output b64sd_pkg::cmd_t rd_cmd,
    output logic            full,
    output logic            empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    b64sd_pkg::cmd_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full   = (count_reg == CNT_MAX);
    assign empty  = (count_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/b64sd_back.sv */
module b64sd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  b64sd_pkg::cmd_t q_cmd,
    output logic            q_rd,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      data_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            stream_done,
    output logic [1:0]      status
);

    b64sd_pkg::cmd_t cur_reg;
    logic [1:0]      idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic            last_beat;
    logic            advance;

    assign last_beat = (idx_reg == cur_reg.nres - 2'd1);
    assign advance   = !valid_reg || (pop && last_beat);
    assign q_rd      = advance && !q_empty;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            idx_next   = 2'd0;
            valid_next = !q_empty;
        end
        else if (pop)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            cur_reg <= q_cmd;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    data_byte = cur_reg.b0;
            2'd1:    data_byte = cur_reg.b1;
            default: data_byte = cur_reg.b2;
        endcase
    end

    assign empty       = !valid_reg;
    assign byte_valid  = (cur_reg.status == b64sd_pkg::ST_OK);
    assign run_last    = last_beat;
    assign stream_done = last_beat && cur_reg.done;
    assign status      = cur_reg.status;

endmodule

/* hdl/base64_stream_decoder.sv */
// Base64 stream decoder, standard alphabet with strict padding. Push one
// encoded character per beat, with final_char set on the last character of
// a stream; pop decoded octets from the result side. Each complete group of
// four characters yields three beats (two or one for a final group ending in
// "=" or "=="); a bad character or a stream whose length is not a multiple
// of four yields a single beat with byte_valid low, stream_done high and a
// nonzero status, and the rest of that stream is dropped up to its final
// character. Rate: one character per clock in while not full, and one result
// beat per clock out while popped with beats waiting. The front classifies a
// character in the cycle it is accepted and writes one command per finished
// group or error into a FIFO_DEPTH-entry command queue; the back expands a
// command into its beats from an output register. With the back idle, the
// edge that accepts a character writes its command into the queue, and the
// back loads it into the output register on the ports. full rises only when
// the command queue is full, so input keeps flowing while results await pop.
module base64_stream_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] enc_char,
    input  logic       final_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       stream_done,
    output logic [1:0] status
);

    b64sd_pkg::cmd_t wr_cmd;
    b64sd_pkg::cmd_t rd_cmd;
    logic            q_wr;
    logic            q_rd;
    logic            q_empty;

    // Front: classify characters, track group position, build commands
    b64sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .enc_char   (enc_char),
        .final_char (final_char),
        .q_full     (full),
        .q_wr       (q_wr),
        .q_cmd      (wr_cmd)
    );

    // Command queue between front and back
    b64sd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_cmd (wr_cmd),
        .rd     (q_rd),
        .rd_cmd (rd_cmd),
        .full   (full),
        .empty  (q_empty)
    );

    // Back: hold one command and advance through its beats
    b64sd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (rd_cmd),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .run_last    (run_last),
        .stream_done (stream_done),
        .status      (status)
    );

`ifndef SYNTH
    // An error beat stands alone and ends the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != b64sd_pkg::ST_OK) |->
            (run_last && stream_done && !byte_valid))
        else $error("error beat not single and final");

    // Only the last beat of a command may close the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_done) |-> run_last)
        else $error("stream_done before last beat");

    // A full queue means the back stage is already holding a command
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while output stage idle");

    // A beat not taken stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(status)))
        else $error("waiting beat changed");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int N_RANDOM     = 100;
    localparam int N_DIR        = 29;
    // Windows without gaps: by item on the push side, by beat on the pop side
    localparam int PUSH_CALM_LO = N_DIR + 50;
    localparam int PUSH_CALM_HI = N_DIR + 90;
    localparam int POP_CALM_LO  = 40;
    localparam int POP_CALM_HI  = 90;
    // Cycles to hold after the last expected beat before calling the run done
    localparam int DRAIN_CYCLES = 16;

    // One result beat as it leaves the decoder
    typedef struct packed {
        logic [7:0]          data;
        logic                valid;
        logic                last;
        logic                done;
        b64sd_pkg::status_t  st;
    } beat_t;

    // One input character; typed rows carry their result beat in the row
    typedef struct packed {
        logic [7:0] c;
        logic       fin;
        logic       typed;
        beat_t      want;
    } char_row_t;

    localparam beat_t NO_BEAT   = '{8'h00, 1'b0, 1'b0, 1'b0, b64sd_pkg::ST_OK};
    localparam beat_t LEN_BEAT  = '{8'h00, 1'b0, 1'b1, 1'b1, b64sd_pkg::ST_LEN};
    localparam beat_t CHAR_BEAT = '{8'h00, 1'b0, 1'b1, 1'b1, b64sd_pkg::ST_CHAR};

    // Directed streams: each one ends on a final character
    localparam char_row_t DIR_TABLE [N_DIR] = '{
        // final on the first character of a stream: length error
        '{b64sd_pkg::CH_UP_A,  1'b1, 1'b1, LEN_BEAT},
        // pad at position zero, then drop up to the final character
        '{b64sd_pkg::CH_PAD,   1'b0, 1'b1, CHAR_BEAT},
        '{8'h00,               1'b1, 1'b0, NO_BEAT},
        // all ones
        '{b64sd_pkg::CH_SLASH, 1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_SLASH, 1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_SLASH, 1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_SLASH, 1'b1, 1'b0, NO_BEAT},
        // single pad in the final group: two octets
        '{b64sd_pkg::CH_LO_Z,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_DIG_9, 1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PLUS,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PAD,   1'b1, 1'b0, NO_BEAT},
        // pad at position three that is not final
        '{b64sd_pkg::CH_UP_Z,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_LO_A,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PAD,   1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PAD,   1'b0, 1'b1, CHAR_BEAT},
        '{8'hFF,               1'b1, 1'b0, NO_BEAT},
        // pad at position one
        '{b64sd_pkg::CH_DIG_0, 1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PAD,   1'b0, 1'b1, CHAR_BEAT},
        '{b64sd_pkg::CH_UP_A,  1'b1, 1'b0, NO_BEAT},
        // bad character on a short final: the length error wins
        '{b64sd_pkg::CH_UP_A,  1'b0, 1'b0, NO_BEAT},
        '{8'hFF,               1'b1, 1'b1, LEN_BEAT},
        // double pad: one octet of zero
        '{b64sd_pkg::CH_UP_A,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_UP_A,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PAD,   1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PAD,   1'b1, 1'b0, NO_BEAT},
        // a data character after a pad at position two
        '{b64sd_pkg::CH_UP_A,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_UP_A,  1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_PAD,   1'b0, 1'b0, NO_BEAT},
        '{b64sd_pkg::CH_UP_A,  1'b1, 1'b1, CHAR_BEAT}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] enc_char = 8'h00;
    logic       final_char = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_done;
    logic [1:0] status;

    base64_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .enc_char    (enc_char),
        .final_char  (final_char),
        .empty       (empty),
        .pop         (pop),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .run_last    (run_last),
        .stream_done (stream_done),
        .status      (status)
    );

    always #4 clk = ~clk;

    char_row_t char_q [$];     // every character to push, in order
    beat_t     octet_q [$];    // beats still owed by the decoder
    beat_t     step_beats [$]; // beats caused by the character just decoded
    int        errors = 0;
    int        n_popped = 0;
    int        cycles = 0;

    // Decoder image: group position, first three sextets, pad and drop flags
    logic [1:0] grp_pos;
    logic [5:0] sx [3];
    logic       pad_flag;
    logic       dropping;

    function automatic void clear_group();
        grp_pos  = 2'd0;
        pad_flag = 1'b0;
        sx[0]    = 6'd0;
        sx[1]    = 6'd0;
        sx[2]    = 6'd0;
    endfunction

    function automatic void emit(input logic [7:0] d, input logic v, input logic l,
                                 input logic dn, input b64sd_pkg::status_t st);
        beat_t b;
        b = '{d, v, l, dn, st};
        step_beats.push_back(b);
    endfunction

    // Report an error beat, restart the group, drop the rest unless final
    function automatic void fail_stream(input b64sd_pkg::status_t st, input logic fin);
        emit(8'h00, 1'b0, 1'b1, 1'b1, st);
        clear_group();
        dropping = !fin;
    endfunction

    function automatic void sextet_of(input logic [7:0] c, output logic ok,
                                      output logic [5:0] v);
        ok = 1'b1;
        v  = 6'd0;
        if (c inside {[b64sd_pkg::CH_UP_A:b64sd_pkg::CH_UP_Z]})
        begin
            v = 6'(c - b64sd_pkg::CH_UP_A);
        end
        else if (c inside {[b64sd_pkg::CH_LO_A:b64sd_pkg::CH_LO_Z]})
        begin
            v = 6'(c - b64sd_pkg::CH_LO_A) + 6'd26;
        end
        else if (c inside {[b64sd_pkg::CH_DIG_0:b64sd_pkg::CH_DIG_9]})
        begin
            v = 6'(c - b64sd_pkg::CH_DIG_0) + 6'd52;
        end
        else if (c == b64sd_pkg::CH_PLUS)
        begin
            v = b64sd_pkg::SX_PLUS;
        end
        else if (c == b64sd_pkg::CH_SLASH)
        begin
            v = b64sd_pkg::SX_SLASH;
        end
        else
        begin
            ok = 1'b0;
        end
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26)
            return b64sd_pkg::CH_UP_A + 8'(v);
        else if (v < 6'd52)
            return b64sd_pkg::CH_LO_A + 8'(v - 6'd26);
        else if (v < 6'd62)
            return b64sd_pkg::CH_DIG_0 + 8'(v - 6'd52);
        else if (v == b64sd_pkg::SX_PLUS)
            return b64sd_pkg::CH_PLUS;
        else
            return b64sd_pkg::CH_SLASH;
    endfunction

    // Advance the decoder image by one character, leaving its beats in step_beats
    function automatic void decode_step(input logic [7:0] c, input logic fin);
        logic       ok;
        logic       pad;
        logic [5:0] v;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        step_beats.delete();
        sextet_of(c, ok, v);
        pad = (c == b64sd_pkg::CH_PAD);
        b0  = {sx[0], sx[1][5:4]};
        b1  = {sx[1][3:0], sx[2][5:2]};
        b2  = {sx[2][1:0], v};
        if (dropping)
        begin
            // swallow everything up to the final character
            if (fin)
            begin
                clear_group();
                dropping = 1'b0;
            end
        end
        else if (fin && grp_pos != b64sd_pkg::POS_LAST)
        begin
            fail_stream(b64sd_pkg::ST_LEN, fin);
        end
        else if (!pad && !ok)
        begin
            fail_stream(b64sd_pkg::ST_CHAR, fin);
        end
        else if (pad)
        begin
            if (grp_pos < b64sd_pkg::POS_PAD)
            begin
                fail_stream(b64sd_pkg::ST_CHAR, fin);
            end
            else if (grp_pos == b64sd_pkg::POS_PAD)
            begin
                pad_flag = 1'b1;
                grp_pos  = b64sd_pkg::POS_LAST;
            end
            else if (!fin)
            begin
                fail_stream(b64sd_pkg::ST_CHAR, fin);
            end
            else if (pad_flag)
            begin
                emit(b0, 1'b1, 1'b1, 1'b1, b64sd_pkg::ST_OK);
                clear_group();
            end
            else
            begin
                emit(b0, 1'b1, 1'b0, 1'b0, b64sd_pkg::ST_OK);
                emit(b1, 1'b1, 1'b1, 1'b1, b64sd_pkg::ST_OK);
                clear_group();
            end
        end
        else if (pad_flag)
        begin
            fail_stream(b64sd_pkg::ST_CHAR, fin);
        end
        else if (grp_pos < b64sd_pkg::POS_LAST)
        begin
            sx[grp_pos] = v;
            grp_pos     = grp_pos + 2'd1;
        end
        else
        begin
            emit(b0, 1'b1, 1'b0, 1'b0, b64sd_pkg::ST_OK);
            emit(b1, 1'b1, 1'b0, 1'b0, b64sd_pkg::ST_OK);
            emit(b2, 1'b1, 1'b1, fin, b64sd_pkg::ST_OK);
            clear_group();
        end
    endfunction

    // Mostly clean streams of one to three groups with random padding; some
    // get one character spoiled or the tail cut off, and some are pure noise
    task automatic add_stream();
        logic [7:0] s [$];
        char_row_t  r;
        int         kind;
        int         ngrp;
        int         npad;
        int         pos;
        int         cut;
        kind = $urandom_range(0, 99);
        ngrp = $urandom_range(1, 3);
        npad = $urandom_range(0, 2);
        for (int i = 0; i < 4 * ngrp; i++)
            s.push_back(sextet_char(6'($urandom_range(0, 63))));
        for (int i = 0; i < npad; i++)
            s[s.size() - 1 - i] = b64sd_pkg::CH_PAD;
        if (kind >= 85)
        begin
            s.delete();
            cut = $urandom_range(1, 6);
            for (int i = 0; i < cut; i++)
                s.push_back(($urandom_range(0, 3) == 0) ? b64sd_pkg::CH_PAD
                                                        : 8'($urandom_range(0, 255)));
        end
        else if (kind >= 70)
        begin
            pos = $urandom_range(0, s.size() - 1);
            case ($urandom_range(0, 2))
                0: s[pos] = 8'($urandom_range(0, 255));
                1: s[pos] = b64sd_pkg::CH_PAD;
                default:
                begin
                    cut = $urandom_range(1, 3);
                    repeat (cut)
                        if (s.size() > 1)
                            void'(s.pop_back());
                end
            endcase
        end
        foreach (s[i])
        begin
            r = '{s[i], (i == s.size() - 1), 1'b0, NO_BEAT};
            char_q.push_back(r);
        end
    endtask

    function automatic bit skip_beat(input bit calm);
        return !calm && ($urandom_range(0, 99) < 38);
    endfunction

    // Compare one popped beat, field by field, against the oldest expectation
    task automatic check_beat();
        beat_t w;
        n_popped++;
        if (octet_q.size() == 0)
        begin
            $display("%0t: beat with nothing expected: data=%h valid=%b last=%b done=%b st=%0d",
                     $time, data_byte, byte_valid, run_last, stream_done, status);
            errors++;
        end
        else
        begin
            w = octet_q.pop_front();
            if (data_byte !== w.data)
            begin
                $display("%0t: data_byte expected %h actual %h", $time, w.data, data_byte);
                errors++;
            end
            if (byte_valid !== w.valid)
            begin
                $display("%0t: byte_valid expected %b actual %b", $time, w.valid, byte_valid);
                errors++;
            end
            if (run_last !== w.last)
            begin
                $display("%0t: run_last expected %b actual %b", $time, w.last, run_last);
                errors++;
            end
            if (stream_done !== w.done)
            begin
                $display("%0t: stream_done expected %b actual %b", $time, w.done, stream_done);
                errors++;
            end
            if (status !== w.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, w.st, status);
                errors++;
            end
        end
    endtask

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: pop at random, check every beat taken
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_beat();
            pop <= !skip_beat(n_popped >= POP_CALM_LO && n_popped < POP_CALM_HI);
        end
    end

    // Input side: build the stimulus, push it, then drain and report
    initial
    begin
        int idx;
        clear_group();
        dropping = 1'b0;
        for (int i = 0; i < N_DIR; i++)
            char_q.push_back(DIR_TABLE[i]);
        while (char_q.size() < N_DIR + N_RANDOM)
            add_stream();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        while (idx < char_q.size())
        begin
            @(posedge clk);
            // A beat went in at this edge: predict what it causes
            if (push && !full)
            begin
                decode_step(enc_char, final_char);
                if (char_q[idx].typed)
                    octet_q.push_back(char_q[idx].want);
                else
                    foreach (step_beats[k])
                        octet_q.push_back(step_beats[k]);
                idx++;
            end
            // Present the next character, or hold off
            if (idx < char_q.size() &&
                !skip_beat(idx >= PUSH_CALM_LO && idx < PUSH_CALM_HI))
            begin
                push       <= 1'b1;
                enc_char   <= char_q[idx].c;
                final_char <= char_q[idx].fin;
            end
            else
            begin
                push <= 1'b0;
            end
        end

        while (octet_q.size() != 0)
            @(posedge clk);
        // Hold a little longer so that any stray beat shows up
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && octet_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
